// ----- rtl/core/sbme_pkg.sv -----
`default_nettype none

package sbme_pkg;

  localparam int STORE_DEPTH_DEF = 65536;

  localparam int POS_W  = 16;
  localparam int LEN_W  = 17;
  localparam int CNT_W  = 17;
  localparam int BYTE_W = 8;
  localparam int RND_W  = 32;
  localparam int IDX_W  = 3;
  localparam int MODE_W = 4;
  localparam int OPC_W  = 2;

  localparam logic [MODE_W-1:0] MODE_SHIFT  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SWAP   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_ADD    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_SET    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_RANDOM = 4'd4;
  localparam logic [MODE_W-1:0] MODE_ROTL   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_ROTR   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_AND    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_OR     = 4'd8;
  localparam logic [MODE_W-1:0] MODE_XOR    = 4'd9;
  localparam logic [MODE_W-1:0] MODE_NOT    = 4'd10;
  localparam logic [MODE_W-1:0] MODE_NONE   = 4'd11;

  localparam logic [OPC_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPC_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPC_W-1:0] OP_RUN   = 2'd2;

  localparam logic [IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_OPERAND = 3'd1;
  localparam logic [IDX_W-1:0] REG_START   = 3'd2;
  localparam logic [IDX_W-1:0] REG_END     = 3'd3;
  localparam logic [IDX_W-1:0] REG_STRIDE  = 3'd4;
  localparam logic [IDX_W-1:0] REG_SEED    = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  operand;
    logic [POS_W-1:0]  start_pos;
    logic [LEN_W-1:0]  end_pos;
    logic [POS_W-1:0]  stride;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0] sum;
    logic             below_len;
    logic             below_end;
  } pos_res_t;

  function automatic logic [RND_W-1:0] xorshift32(input logic [RND_W-1:0] v);
    logic [RND_W-1:0] x;
    x = v;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sbme_store.sv -----
`default_nettype none

module sbme_store #(
  parameter int DEPTH = sbme_pkg::STORE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [sbme_pkg::BYTE_W-1:0] wdata_i,
  input  wire logic                      re_i,
  input  wire logic [AW-1:0]             raddr_i,
  output logic      [sbme_pkg::BYTE_W-1:0] rdata_o
);
  import sbme_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/sbme_pos_unit.sv -----
`default_nettype none

module sbme_pos_unit (
  input  wire logic [sbme_pkg::POS_W-1:0] base_i,
  input  wire logic [sbme_pkg::POS_W-1:0] addend_i,
  input  wire logic [sbme_pkg::LEN_W-1:0] len_i,
  input  wire logic [sbme_pkg::LEN_W-1:0] end_pos_i,
  output sbme_pkg::pos_res_t              res_o
);
  import sbme_pkg::*;

  logic [LEN_W-1:0] sum;

  assign sum             = {1'b0, base_i} + {1'b0, addend_i};
  assign res_o.sum       = sum;
  assign res_o.below_len = sum < len_i;
  assign res_o.below_end = {1'b0, base_i} < end_pos_i;

endmodule

`default_nettype wire

// ----- rtl/core/sbme_byte_alu.sv -----
`default_nettype none

module sbme_byte_alu (
  input  wire logic [sbme_pkg::MODE_W-1:0] mode_i,
  input  wire logic [sbme_pkg::POS_W-1:0]  operand_i,
  input  wire logic [sbme_pkg::BYTE_W-1:0] din_i,
  output logic      [sbme_pkg::BYTE_W-1:0] dout_o
);
  import sbme_pkg::*;

  logic [BYTE_W-1:0] k;
  logic [2:0]        n;
  logic [2:0]        nr;
  logic [2*BYTE_W-1:0] dbl;
  logic [2*BYTE_W-1:0] shl;
  logic [2*BYTE_W-1:0] shr;

  assign k   = operand_i[BYTE_W-1:0];
  assign n   = operand_i[2:0];
  assign nr  = 3'd0 - n;
  assign dbl = {din_i, din_i};
  assign shl = dbl << n;
  assign shr = dbl << nr;

  always_comb begin
    unique case (mode_i)
      MODE_ADD:  dout_o = din_i + k;
      MODE_SET:  dout_o = k;
      MODE_ROTL: dout_o = shl[2*BYTE_W-1:BYTE_W];
      MODE_ROTR: dout_o = shr[2*BYTE_W-1:BYTE_W];
      MODE_AND:  dout_o = din_i & k;
      MODE_OR:   dout_o = din_i | k;
      MODE_XOR:  dout_o = din_i ^ k;
      MODE_NOT:  dout_o = ~din_i;
      default:   dout_o = din_i;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/strided_byte_mutation_engine.sv -----
`default_nettype none

// Byte store with a strided mutation pass. Opcode 0 writes a byte, 1 reads one,
// 2 runs a pass over positions start_pos, start_pos+stride, ... and returns the
// number of mutations applied. A run with zero stride or mode none makes no
// pass. Per position, random writes a fresh byte, the byte ops read, modify and
// write back, shift copies the byte at the other position here, swap exchanges
// the two; shift or swap skip a position whose other one is past the length.
// A result that is not taken holds the block in its done state. The store has
// one read and one write port; one position adder serves stride and operand.
// The store holds garbage until written; no clearing pass is done.
module strided_byte_mutation_engine #(
  parameter int STORE_DEPTH = sbme_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sbme_pkg::IDX_W-1:0]    cfg_idx_i,
  input  wire logic [sbme_pkg::RND_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [sbme_pkg::OPC_W-1:0]    opcode_i,
  input  wire logic [sbme_pkg::POS_W-1:0]    address_i,
  input  wire logic [sbme_pkg::BYTE_W-1:0]   write_byte_i,
  input  wire logic [sbme_pkg::LEN_W-1:0]    data_length_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [sbme_pkg::BYTE_W-1:0]   read_byte_o,
  output logic      [sbme_pkg::CNT_W-1:0]    change_count_o
);
  import sbme_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_OTH   = 4'd2;
  localparam logic [3:0] ST_SHW   = 4'd3;
  localparam logic [3:0] ST_SWA   = 4'd4;
  localparam logic [3:0] ST_SWB   = 4'd5;
  localparam logic [3:0] ST_SWC   = 4'd6;
  localparam logic [3:0] ST_MOD   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]        state_q, state_d;
  cfg_t              cfg_q;
  logic [RND_W-1:0]  rand_q, rand_d;
  logic              out_valid_q, out_valid_d;

  logic [OPC_W-1:0]  op_q, op_d;
  logic              addr_ok_q, addr_ok_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [LEN_W-1:0]  nxt_q, nxt_d;
  logic [POS_W-1:0]  oth_q, oth_d;
  logic [BYTE_W-1:0] tmp_q, tmp_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  logic              st_we, st_re;
  logic [AW-1:0]     st_waddr, st_raddr;
  logic [BYTE_W-1:0] st_wdata, st_rdata;

  logic [POS_W-1:0]  pu_addend;
  pos_res_t          pu_res;
  logic [BYTE_W-1:0] alu_out;
  logic [RND_W-1:0]  rnd_next;
  logic              in_fire;

  sbme_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  assign pu_addend = (state_q == ST_OTH) ? cfg_q.operand : cfg_q.stride;

  sbme_pos_unit u_pos (
    .base_i   (pos_q),
    .addend_i (pu_addend),
    .len_i    (len_q),
    .end_pos_i(cfg_q.end_pos),
    .res_o    (pu_res)
  );

  sbme_byte_alu u_alu (
    .mode_i   (cfg_q.mode),
    .operand_i(cfg_q.operand),
    .din_i    (st_rdata),
    .dout_o   (alu_out)
  );

  assign rnd_next   = xorshift32(rand_q);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    rand_d      = rand_q;
    out_valid_d = out_valid_q && !out_ready_i;
    op_d        = op_q;
    addr_ok_d   = addr_ok_q;
    len_d       = len_q;
    pos_d       = pos_q;
    nxt_d       = nxt_q;
    oth_d       = oth_q;
    tmp_d       = tmp_q;
    cnt_d       = cnt_q;
    out_byte_d  = out_byte_q;
    out_cnt_d   = out_cnt_q;
    st_we       = 1'b0;
    st_re       = 1'b0;
    st_waddr    = AW'(pos_q);
    st_raddr    = AW'(pos_q);
    st_wdata    = alu_out;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d      = opcode_i;
          cnt_d     = '0;
          addr_ok_d = 32'(address_i) < STORE_DEPTH;
          state_d   = ST_DONE;
          unique case (opcode_i)
            OP_WRITE: begin
              st_we    = addr_ok_d;
              st_waddr = AW'(address_i);
              st_wdata = write_byte_i;
            end
            OP_READ: begin
              st_re    = addr_ok_d;
              st_raddr = AW'(address_i);
            end
            OP_RUN: begin
              len_d = (32'(data_length_i) > STORE_DEPTH) ? LEN_W'(STORE_DEPTH)
                                                          : data_length_i;
              pos_d = cfg_q.start_pos;
              if (cfg_q.stride != '0 && cfg_q.mode <= MODE_NOT) begin
                state_d = ST_CHECK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (!(pu_res.below_len && pu_res.below_end)) begin
          state_d = ST_DONE;
        end else begin
          nxt_d = pu_res.sum;
          unique case (cfg_q.mode)
            MODE_SHIFT, MODE_SWAP: state_d = ST_OTH;
            MODE_RANDOM: begin
              st_we    = 1'b1;
              st_wdata = rnd_next[BYTE_W-1:0];
              rand_d   = rnd_next;
              cnt_d    = cnt_q + 1'b1;
              pos_d    = pu_res.sum[POS_W-1:0];
            end
            default: begin
              st_re   = 1'b1;
              state_d = ST_MOD;
            end
          endcase
        end
      end
      ST_OTH: begin
        if (!pu_res.below_len) begin
          pos_d   = nxt_q[POS_W-1:0];
          state_d = ST_CHECK;
        end else begin
          oth_d    = pu_res.sum[POS_W-1:0];
          st_re    = 1'b1;
          st_raddr = AW'(pu_res.sum[POS_W-1:0]);
          state_d  = (cfg_q.mode == MODE_SHIFT) ? ST_SHW : ST_SWA;
        end
      end
      ST_SHW: begin
        st_we    = 1'b1;
        st_wdata = st_rdata;
        cnt_d    = cnt_q + 1'b1;
        pos_d    = nxt_q[POS_W-1:0];
        state_d  = ST_CHECK;
      end
      ST_SWA: begin
        tmp_d   = st_rdata;
        st_re   = 1'b1;
        state_d = ST_SWB;
      end
      ST_SWB: begin
        st_we    = 1'b1;
        st_waddr = AW'(oth_q);
        st_wdata = st_rdata;
        state_d  = ST_SWC;
      end
      ST_SWC: begin
        st_we    = 1'b1;
        st_wdata = tmp_q;
        cnt_d    = cnt_q + 1'b1;
        pos_d    = nxt_q[POS_W-1:0];
        state_d  = ST_CHECK;
      end
      ST_MOD: begin
        st_we   = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        pos_d   = nxt_q[POS_W-1:0];
        state_d = ST_CHECK;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_byte_d  = (op_q == OP_READ && addr_ok_q) ? st_rdata : '0;
          out_cnt_d   = cnt_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i && cfg_idx_i == REG_SEED) begin
      rand_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      out_valid_q     <= 1'b0;
      cfg_q.mode      <= MODE_NONE;
      cfg_q.operand   <= '0;
      cfg_q.start_pos <= '0;
      cfg_q.end_pos   <= LEN_W'(65536);
      cfg_q.stride    <= POS_W'(1);
      rand_q          <= RND_W'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rand_q      <= rand_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MODE:    cfg_q.mode      <= cfg_data_i[MODE_W-1:0];
          REG_OPERAND: cfg_q.operand   <= cfg_data_i[POS_W-1:0];
          REG_START:   cfg_q.start_pos <= cfg_data_i[POS_W-1:0];
          REG_END:     cfg_q.end_pos   <= cfg_data_i[LEN_W-1:0];
          REG_STRIDE:  cfg_q.stride    <= cfg_data_i[POS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    addr_ok_q  <= addr_ok_d;
    len_q      <= len_d;
    pos_q      <= pos_d;
    nxt_q      <= nxt_d;
    oth_q      <= oth_d;
    tmp_q      <= tmp_d;
    cnt_q      <= cnt_d;
    out_byte_q <= out_byte_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign out_valid_o    = out_valid_q;
  assign read_byte_o    = out_byte_q;
  assign change_count_o = out_cnt_q;

  a_check_stride: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> cfg_q.stride != '0)
    else $error("pass running with zero stride");

  a_pos_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD || state_q == ST_OTH || state_q == ST_SHW) |->
      {1'b0, pos_q} < len_q)
    else $error("visited position outside length");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside completion");

endmodule

`default_nettype wire
